[src/hsv_pkg.sv]
`timescale 1ns / 1ps

package hsv_pkg;

    localparam int CH_W    = 8;
    localparam int HUE_W   = 9;
    localparam int QUOT_W  = 8;   // quotient bits, one per cell
    localparam int N_CELLS = QUOT_W;

    localparam logic [HUE_W-1:0] HUE_BASE_R  = 9'd0;
    localparam logic [HUE_W-1:0] HUE_BASE_G  = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BASE_B  = 9'd240;
    localparam logic [HUE_W-1:0] HUE_BASE_RW = 9'd360;
    localparam logic [HUE_W-1:0] HUE_MAX     = 9'd360;

    // one restoring divider: partial remainder plus numerator/quotient shift word
    typedef struct packed {
        logic [CH_W-1:0] rem;
        logic [QUOT_W-1:0] sh;
    } div_t;

    // everything one pixel carries down the chain
    typedef struct packed {
        div_t              hdiv;
        logic [CH_W-1:0]   hden;
        div_t              sdiv;
        logic [CH_W-1:0]   vmax;   // also the saturation divisor
        logic [HUE_W-1:0]  base;
        logic              neg;
        logic              gray;
    } lane_t;

    function automatic div_t div_step(input div_t d, input logic [CH_W-1:0] den);
        logic [CH_W:0] trial;
        logic          qbit;
        div_t          res;
        trial = {d.rem, d.sh[QUOT_W-1]};
        qbit  = (trial >= {1'b0, den});
        if (qbit) begin
            trial = trial - {1'b0, den};
        end
        res.rem = trial[CH_W-1:0];
        res.sh  = {d.sh[QUOT_W-2:0], qbit};
        return res;
    endfunction

endpackage

[src/rgb_to_hsv_integer_top.sv]
`timescale 1ns / 1ps

// channel   direction  tdata fields (lsb first)                      width
// s_axis    in         red[7:0] green[15:8] blue[23:16]              24
// m_axis    out        hue[8:0] saturation[16:9] brightness[24:17]  32 (bits 31:25 zero)
//
// one pixel per clock sustained while the output is ready; each pixel passes through
// the sort stage, 8 divider cells at one quotient bit each, and the output register
// every stage has its own valid bit, so bubbles close up under backpressure
// aresetn (synchronous, active low) clears the valid bits only

module rgb_to_hsv_integer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // hue, saturation, brightness, zero pad
);

    logic                      vld [hsv_pkg::N_CELLS+1];
    logic                      rdy [hsv_pkg::N_CELLS+1];
    hsv_pkg::lane_t            lane [hsv_pkg::N_CELLS+1];
    logic [hsv_pkg::HUE_W-1:0] hue;
    logic [hsv_pkg::CH_W-1:0]  saturation;
    logic [hsv_pkg::CH_W-1:0]  brightness;

    hsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red       (s_axis_tdata[7:0]),
        .green     (s_axis_tdata[15:8]),
        .blue      (s_axis_tdata[23:16]),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_lane  (lane[0])
    );

    for (genvar i = 0; i < hsv_pkg::N_CELLS; i++) begin : g_cell
        hsv_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_lane   (lane[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_lane  (lane[i+1])
        );
    end

    hsv_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (vld[hsv_pkg::N_CELLS]),
        .in_ready   (rdy[hsv_pkg::N_CELLS]),
        .in_lane    (lane[hsv_pkg::N_CELLS]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    assign m_axis_tdata = {7'b0, brightness, saturation, hue};

`ifndef SYNTHESIS
    // a free output must never stall the input side
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (hue <= hsv_pkg::HUE_MAX))
        else $error("hue above 360");

    // zero saturation only for gray, and gray has hue zero
    a_gray_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (saturation == '0)) |-> (hue == '0))
        else $error("zero saturation with nonzero hue");

    a_black_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (brightness == '0)) |-> (saturation == '0))
        else $error("black pixel with nonzero saturation");
`endif

endmodule

[src/hsv_front.sv]
`timescale 1ns / 1ps

module hsv_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [hsv_pkg::CH_W-1:0] red,
    input  logic [hsv_pkg::CH_W-1:0] green,
    input  logic [hsv_pkg::CH_W-1:0] blue,
    output logic                     out_valid,
    input  logic                     out_ready,
    output hsv_pkg::lane_t           out_lane
);

    logic                     valid_reg;
    logic                     valid_next;
    hsv_pkg::lane_t           lane_reg;
    hsv_pkg::lane_t           lane_next;

    logic [hsv_pkg::CH_W-1:0] mx;
    logic [hsv_pkg::CH_W-1:0] mn;
    logic [hsv_pkg::CH_W-1:0] num;
    logic [hsv_pkg::CH_W-1:0] dif;
    logic [hsv_pkg::HUE_W-1:0] base;
    logic                     neg;
    logic                     gray;
    logic [13:0]              hnum;
    logic [15:0]              snum;

    // pick max, min and the hue sector as the conversion's branch order does
    always_comb begin
        mx   = green;
        mn   = green;
        num  = '0;
        base = hsv_pkg::HUE_BASE_R;
        neg  = 1'b0;
        gray = 1'b0;
        if (red > green) begin
            if (blue > red) begin
                mx = blue;  mn = green; base = hsv_pkg::HUE_BASE_B;  num = red - green;
            end else if (green < blue) begin
                mx = red;   mn = green; base = hsv_pkg::HUE_BASE_RW; num = blue - green;
                neg = 1'b1;
            end else begin
                mx = red;   mn = blue;  base = hsv_pkg::HUE_BASE_R;  num = green - blue;
            end
        end else if (blue < red) begin
            mx = green; mn = blue;  base = hsv_pkg::HUE_BASE_G;  num = red - blue;
            neg = 1'b1;
        end else if (green < blue) begin
            mx = blue;  mn = red;   base = hsv_pkg::HUE_BASE_B;  num = green - red;
            neg = 1'b1;
        end else if (green != red) begin
            mx = green; mn = red;   base = hsv_pkg::HUE_BASE_G;  num = blue - red;
        end else begin
            gray = 1'b1;
        end
    end

    assign dif  = mx - mn;
    // num * 60 and dif * 255 by shift and subtract
    assign hnum = {num, 6'b0} - {4'b0, num, 2'b0};
    assign snum = {dif, 8'b0} - {8'b0, dif};

    always_comb begin
        lane_next.hdiv.rem = {2'b0, hnum[13:8]};
        lane_next.hdiv.sh  = hnum[7:0];
        lane_next.hden     = dif;
        lane_next.sdiv.rem = snum[15:8];
        lane_next.sdiv.sh  = snum[7:0];
        lane_next.vmax     = mx;
        lane_next.base     = base;
        lane_next.neg      = neg;
        lane_next.gray     = gray;
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

[src/hsv_cell.sv]
`timescale 1ns / 1ps

module hsv_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  hsv_pkg::lane_t in_lane,
    output logic           out_valid,
    input  logic           out_ready,
    output hsv_pkg::lane_t out_lane
);

    logic           valid_reg;
    logic           valid_next;
    hsv_pkg::lane_t lane_reg;
    hsv_pkg::lane_t lane_next;

    // one quotient bit of each division
    always_comb begin
        lane_next      = in_lane;
        lane_next.hdiv = hsv_pkg::div_step(in_lane.hdiv, in_lane.hden);
        lane_next.sdiv = hsv_pkg::div_step(in_lane.sdiv, in_lane.vmax);
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

[src/hsv_back.sv]
`timescale 1ns / 1ps

module hsv_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hsv_pkg::lane_t            in_lane,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [hsv_pkg::HUE_W-1:0] hue,
    output logic [hsv_pkg::CH_W-1:0]  saturation,
    output logic [hsv_pkg::CH_W-1:0]  brightness
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [hsv_pkg::HUE_W-1:0] hue_reg;
    logic [hsv_pkg::HUE_W-1:0] hue_next;
    logic [hsv_pkg::CH_W-1:0]  sat_reg;
    logic [hsv_pkg::CH_W-1:0]  sat_next;
    logic [hsv_pkg::CH_W-1:0]  val_reg;
    logic [hsv_pkg::HUE_W-1:0] hq;

    assign hq = {1'b0, in_lane.hdiv.sh};

    // gray has a zero hue divisor, so its hue quotient is meaningless
    always_comb begin
        if (in_lane.gray) begin
            hue_next = '0;
            sat_next = '0;
        end else begin
            hue_next = in_lane.neg ? in_lane.base - hq : in_lane.base + hq;
            sat_next = in_lane.sdiv.sh;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= in_lane.vmax;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = val_reg;

endmodule
